// ===== rtl/core/cpr_pkg.sv =====
// Shared types and constants for the clock page replacement block.
`default_nettype none

package cpr_pkg;

  // Field widths of the input and result beats
  localparam int PageW   = 6;
  localparam int FrameW  = 8;
  localparam int OwnerW  = 8;

  // Configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgPolicy  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgProcess = 1'b1;

  // Command codes
  localparam logic [1:0] CmdRead    = 2'd0;
  localparam logic [1:0] CmdWrite   = 2'd1;
  localparam logic [1:0] CmdInstall = 2'd2;
  localparam logic [1:0] CmdReplace = 2'd3;

  // Input beat
  typedef struct packed {
    logic [1:0]        command;
    logic [PageW-1:0]  page;
    logic [FrameW-1:0] frame;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [PageW-1:0]  victim_page;
    logic [FrameW-1:0] victim_frame;
    logic              needs_writeback;
    logic [OwnerW-1:0] owner;
    logic              status;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic ref_cmp;
    logic install;
    logic scan_step;
    logic search_init;
    logic search_step;
    logic vic_read;
    logic vic_commit;
    logic res_zero;
    logic res_empty;
    logic push;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_ref;
    logic is_install;
    logic page_ok;
    logic frame_ok;
    logic ptr_last;
    logic cnt_zero;
    logic found;
    logic out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cpr_datapath.sv =====
// Page table storage, scan counters, frame memory and result registers.
`default_nettype none

module cpr_datapath import cpr_pkg::*; #(
  parameter int PAGES  = 64,
  parameter int FRAMES = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire in_beat_t            in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire ctrl_cmd_t           cmd_i,
  output ctrl_stat_t               stat_o,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output out_beat_t                out_data_o
);

  localparam int PW = $clog2(PAGES);
  localparam int HW = $clog2(PAGES + 1);
  localparam logic [PW-1:0] LastPage  = PW'(PAGES - 1);
  localparam logic [1:0]    ClearPass = 2'd1;
  localparam logic [1:0]    LastPass  = 2'd3;
  localparam out_beat_t     EmptyResult = '{victim_page: '0, victim_frame: '0,
                                            needs_writeback: 1'b0, owner: '0,
                                            status: 1'b1};

  // Latched input beat and configuration
  in_beat_t          in_q;
  logic              policy_q;
  logic [OwnerW-1:0] proc_q;

  // Per-page flags and frame memory
  logic [PAGES-1:0]  present_q, used_q, dirty_q;
  logic [FrameW-1:0] frame_mem [PAGES];
  logic [FrameW-1:0] rdata_q;

  // Scan and search counters
  logic [PW-1:0] ptr_q, first_q, hit_q, victim_q;
  logic          first_seen_q, hit_seen_q;
  logic [HW-1:0] cnt_q, hand_q, rank_q, visits_q;
  logic [1:0]    pass_q;

  // Result registers
  out_beat_t res_q, out_q;
  logic      out_valid_q;

  logic [PW-1:0]     page_idx, ptr_next, rd_addr, wr_addr;
  logic [FrameW-1:0] wr_data;
  logic              wr_en;
  logic              cur_present, cur_used, cur_dirty, visit_hit, clear_pass;
  logic [HW-1:0]     rank_inc;
  logic              rank_wrap, visits_last, victim_dirty;
  logic [PAGES-1:0]  present_vic, dirty_vic;

  // Decode of the current slot
  always_comb begin
    page_idx    = PW'(in_q.page);
    ptr_next    = (ptr_q == LastPage) ? '0 : ptr_q + 1'b1;
    cur_present = present_q[ptr_q];
    cur_used    = used_q[ptr_q];
    cur_dirty   = dirty_q[ptr_q];
    clear_pass  = (pass_q == ClearPass);
    visit_hit   = cur_present && !cur_used && (!policy_q || (cur_dirty == pass_q[0]));
    rank_inc    = rank_q + 1'b1;
    rank_wrap   = (rank_inc == cnt_q);
    visits_last = (visits_q == cnt_q - 1'b1);
    victim_dirty = dirty_q[victim_q];
  end

  // Flags after the victim leaves and the new page moves in
  always_comb begin
    present_vic           = present_q;
    present_vic[victim_q] = 1'b0;
    present_vic[page_idx] = 1'b1;
    dirty_vic             = dirty_q;
    dirty_vic[victim_q]   = 1'b0;
    dirty_vic[page_idx]   = 1'b0;
  end

  // Status to the controller
  always_comb begin
    stat_o.is_ref     = (in_q.command == CmdRead) || (in_q.command == CmdWrite);
    stat_o.is_install = (in_q.command == CmdInstall);
    stat_o.page_ok    = int'(in_q.page) < PAGES;
    stat_o.frame_ok   = int'(in_q.frame) < FRAMES;
    stat_o.ptr_last   = (ptr_q == LastPage);
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.found      = visit_hit;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Input latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_data_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0;
      proc_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgPolicy) begin
        policy_q <= cfg_data_i[0];
      end
      if (cfg_index_i == CfgProcess) begin
        proc_q <= OwnerW'(cfg_data_i);
      end
    end
  end

  // Frame memory: one write, one registered read
  always_comb begin
    rd_addr = cmd_i.vic_read ? victim_q : ptr_q;
    wr_en   = cmd_i.install || cmd_i.vic_commit;
    wr_addr = page_idx;
    wr_data = cmd_i.install ? in_q.frame : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= frame_mem[rd_addr];
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_data;
    end
  end

  // Flags, hand and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      used_q       <= '0;
      dirty_q      <= '0;
      hand_q       <= '0;
      ptr_q        <= '0;
      cnt_q        <= '0;
      rank_q       <= '0;
      visits_q     <= '0;
      pass_q       <= '0;
      first_q      <= '0;
      hit_q        <= '0;
      victim_q     <= '0;
      first_seen_q <= 1'b0;
      hit_seen_q   <= 1'b0;
    end else begin
      if (cmd_i.latch_in) begin
        ptr_q        <= '0;
        cnt_q        <= '0;
        first_seen_q <= 1'b0;
        hit_seen_q   <= 1'b0;
      end

      // reference: compare one stored frame per step
      if (cmd_i.ref_cmp) begin
        if (cur_present && (rdata_q == in_q.frame)) begin
          used_q[ptr_q] <= 1'b1;
          if (in_q.command == CmdWrite) begin
            dirty_q[ptr_q] <= 1'b1;
          end
        end
        ptr_q <= ptr_next;
      end

      if (cmd_i.install) begin
        present_q[page_idx] <= 1'b1;
        dirty_q[page_idx]   <= 1'b0;
      end

      // count resident pages, find the one the hand points at
      if (cmd_i.scan_step) begin
        if (cur_present) begin
          if (cnt_q == hand_q) begin
            hit_q      <= ptr_q;
            hit_seen_q <= 1'b1;
          end
          if (!first_seen_q) begin
            first_q      <= ptr_q;
            first_seen_q <= 1'b1;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        ptr_q <= ptr_next;
      end

      // hand past the end wraps to the first resident page
      if (cmd_i.search_init) begin
        ptr_q    <= hit_seen_q ? hit_q : first_q;
        rank_q   <= hit_seen_q ? hand_q : '0;
        visits_q <= '0;
        pass_q   <= '0;
      end

      // one page slot per step; absent pages are skipped
      if (cmd_i.search_step) begin
        if (visit_hit) begin
          victim_q <= ptr_q;
          hand_q   <= rank_inc;
        end else begin
          if (cur_present) begin
            if (clear_pass) begin
              used_q[ptr_q] <= 1'b0;
            end
            rank_q <= rank_wrap ? '0 : rank_inc;
            if (visits_last) begin
              visits_q <= '0;
              pass_q   <= pass_q + 1'b1;
            end else begin
              visits_q <= visits_q + 1'b1;
            end
          end
          ptr_q <= ptr_next;
        end
      end

      // victim leaves, new page takes its frame
      if (cmd_i.vic_commit) begin
        present_q        <= present_vic;
        dirty_q          <= dirty_vic;
        used_q[page_idx] <= 1'b1;
      end
    end
  end

  // Pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_zero) begin
      res_q <= '0;
    end else if (cmd_i.res_empty) begin
      res_q <= EmptyResult;
    end else if (cmd_i.vic_commit) begin
      res_q.victim_page     <= PageW'(victim_q);
      res_q.victim_frame    <= rdata_q;
      res_q.needs_writeback <= victim_dirty;
      res_q.owner           <= victim_dirty ? proc_q : '0;
      res_q.status          <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_plain_three_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.search_step && !policy_q) |-> (pass_q != LastPass))
    else $error("plain clock search ran into a fourth pass");

  a_victim_resident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.vic_commit |-> present_q[victim_q])
    else $error("victim page is not resident");

  a_rank_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.search_step |-> ((rank_q < cnt_q) && (visits_q < cnt_q)))
    else $error("search rank or visit count out of range");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> out_valid_q)
    else $error("pushed result not presented");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cpr_ctrl.sv =====
// Sequencer for references, installs and the victim search.
`default_nettype none

module cpr_ctrl import cpr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire ctrl_stat_t stat_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REF_RD,
    ST_REF_CMP,
    ST_PRESCAN,
    ST_SEARCH_INIT,
    ST_SEARCH,
    ST_VIC_RD,
    ST_VIC_WR,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (stat_i.is_ref) begin
          state_d = ST_REF_RD;
        end else if (stat_i.is_install) begin
          cmd_o.install  = stat_i.page_ok && stat_i.frame_ok;
          cmd_o.res_zero = 1'b1;
          state_d        = ST_DONE;
        end else if (!stat_i.page_ok) begin
          cmd_o.res_zero = 1'b1;
          state_d        = ST_DONE;
        end else begin
          state_d = ST_PRESCAN;
        end
      end
      ST_REF_RD: begin
        state_d = ST_REF_CMP;
      end
      ST_REF_CMP: begin
        cmd_o.ref_cmp = 1'b1;
        if (stat_i.ptr_last) begin
          cmd_o.res_zero = 1'b1;
          state_d        = ST_DONE;
        end else begin
          state_d = ST_REF_RD;
        end
      end
      ST_PRESCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.ptr_last) begin
          state_d = ST_SEARCH_INIT;
        end
      end
      ST_SEARCH_INIT: begin
        if (stat_i.cnt_zero) begin
          cmd_o.res_empty = 1'b1;
          state_d         = ST_DONE;
        end else begin
          cmd_o.search_init = 1'b1;
          state_d           = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (stat_i.found) begin
          state_d = ST_VIC_RD;
        end
      end
      ST_VIC_RD: begin
        cmd_o.vic_read = 1'b1;
        state_d        = ST_VIC_WR;
      end
      ST_VIC_WR: begin
        cmd_o.vic_commit = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/clock_page_replacement.sv =====
// Top level of the clock page replacement block.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one command beat:
// read or write reference by frame, install of a page into a frame, or
// replace. Every beat gives exactly one result beat on out_valid_o /
// out_stall_i / out_data_o, in order. The block handles one beat at a time;
// in_stall_o is low only while the sequencer is idle.
// Steps from accepting a beat to loading the result register:
//   install or out-of-range page: decode only
//   read or write reference: one frame memory read and compare per page
//     slot, through the single registered read port
//   replace: a counting scan over every page slot, the search set-up, the
//     search steps (one page slot per cycle), the victim read and the commit
// The next input beat is taken once the result is in the output register.
// A finished result sits in the output register while out_stall_i is high;
// the next input beat is still taken and processed, and its result waits
// until the output register frees up.
// Configuration (cfg_we_i, cfg_index_i, cfg_data_i) must be written while idle;
// the block does not enforce it. Reset (rst_ni low) clears all page flags, the
// clock hand, config registers and output valid; no clearing pass is needed.
`default_nettype none

module clock_page_replacement import cpr_pkg::*; #(
  parameter int PAGES  = 64,
  parameter int FRAMES = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_beat_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_beat_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Sequencer
  cpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage and datapath
  cpr_datapath #(
    .PAGES  (PAGES),
    .FRAMES (FRAMES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== test/clock_page_replacement_tb.sv =====
// Self-checking testbench for the clock page replacement block.
`timescale 1ns / 1ps

module clock_page_replacement_tb import cpr_pkg::*;;

  localparam int NPAGES         = 64;
  localparam int PHASE_BEATS    = 205;
  localparam int DRAIN_CYCLES   = 340;   // covers the longest replace, with margin
  localparam int WATCHDOG_LIMIT = 3000;

  // How a directed row gets its expected result
  typedef enum logic [1:0] {ExpPredict, ExpZero, ExpEmpty} exp_kind_e;
  // Modified-bit condition of one pass of the hand
  typedef enum logic [1:0] {WantClean, WantDirty, WantAny} dirty_req_e;

  typedef struct {
    in_beat_t  beat;
    exp_kind_e kind;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_beat_t         in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_beat_t        out_data_o;
  logic             cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Shadow page table and registers
  bit         pg_present [NPAGES];
  bit         pg_used    [NPAGES];
  bit         pg_dirty   [NPAGES];
  logic [7:0] pg_frame   [NPAGES];
  int         hand_pos;
  int         ring [NPAGES];
  bit         clock_m;
  logic [7:0] owner_id;

  out_beat_t  pending_results [$];
  plan_row_t  plan [$];
  int         mismatches;
  int         beats_sent;
  int         settings_used;
  int         replace_cnt;
  int         writeback_cnt;
  int         empty_cnt;
  bit         send_calm;
  bit         recv_calm;

  clock_page_replacement dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int idle_draw(bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // One pass of the hand over the n resident pages
  function automatic int hand_sweep(int n, dirty_req_e req, bit clear_use);
    int p;
    for (int i = 0; i < n; i++) begin
      if (hand_pos >= n) hand_pos = 0;
      p = ring[hand_pos];
      hand_pos = hand_pos + 1;
      if (!pg_used[p] && (req == WantAny || pg_dirty[p] == (req == WantDirty)))
        return p;
      if (clear_use) pg_used[p] = 1'b0;
    end
    return -1;
  endfunction

  // Applies one command beat to the shadow table and returns its result
  function automatic out_beat_t page_table_step(in_beat_t b);
    out_beat_t r;
    int n;
    int v;
    logic [7:0] vf;
    r = '0;
    case (b.command)
      CmdRead, CmdWrite: begin
        for (int p = 0; p < NPAGES; p++) begin
          if (pg_present[p] && pg_frame[p] == b.frame) begin
            pg_used[p] = 1'b1;
            if (b.command == CmdWrite) pg_dirty[p] = 1'b1;
          end
        end
      end
      CmdInstall: begin
        pg_frame[b.page]   = b.frame;
        pg_present[b.page] = 1'b1;
        pg_dirty[b.page]   = 1'b0;
      end
      default: begin
        replace_cnt++;
        n = 0;
        for (int p = 0; p < NPAGES; p++) begin
          if (pg_present[p]) begin
            ring[n] = p;
            n = n + 1;
          end
        end
        v = -1;
        if (n > 0) begin
          if (!clock_m) begin
            v = hand_sweep(n, WantAny, 1'b0);
            if (v < 0) v = hand_sweep(n, WantAny, 1'b1);
            if (v < 0) v = hand_sweep(n, WantAny, 1'b0);
          end else begin
            v = hand_sweep(n, WantClean, 1'b0);
            if (v < 0) v = hand_sweep(n, WantDirty, 1'b1);
            if (v < 0) v = hand_sweep(n, WantClean, 1'b0);
            if (v < 0) v = hand_sweep(n, WantDirty, 1'b0);
          end
        end
        if (v < 0) begin
          r.status = 1'b1;
          empty_cnt++;
        end else begin
          vf = pg_frame[v];
          r.victim_page     = PageW'(v);
          r.victim_frame    = vf;
          r.needs_writeback = pg_dirty[v];
          r.owner           = pg_dirty[v] ? owner_id : '0;
          if (pg_dirty[v]) writeback_cnt++;
          pg_present[v]      = 1'b0;
          pg_dirty[v]        = 1'b0;
          pg_frame[b.page]   = vf;
          pg_present[b.page] = 1'b1;
          pg_used[b.page]    = 1'b1;
          pg_dirty[b.page]   = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_resident();
    int cand [$];
    for (int p = 0; p < NPAGES; p++)
      if (pg_present[p]) cand.push_back(p);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // Mostly references to resident frames, installs and replaces, some noise;
  // shrinking phases aim replaces at resident pages to thin out the set
  function automatic in_beat_t random_beat(bit shrink);
    in_beat_t b;
    int r;
    int rp;
    b.command = CmdRead;
    b.page    = PageW'($urandom_range(0, 63));
    b.frame   = FrameW'($urandom_range(0, 255));
    rp = pick_resident();
    r  = $urandom_range(0, 99);
    if (rp < 0 || r < (shrink ? 5 : 18)) begin
      b.command = CmdInstall;
      if (rp >= 0 && $urandom_range(0, 1) == 1) b.frame = pg_frame[pick_resident()];
    end else if (r < 58) begin
      b.command = ($urandom_range(0, 1) == 1) ? CmdWrite : CmdRead;
      if ($urandom_range(0, 3) != 0) b.frame = pg_frame[rp];
    end else if (r < 92) begin
      b.command = CmdReplace;
      if (shrink && $urandom_range(0, 9) < 7) b.page = PageW'(rp);
    end else begin
      b.command = 2'($urandom_range(0, 3));
    end
    return b;
  endfunction

  function automatic plan_row_t mk_row(logic [1:0] cmd, int page, int frame, exp_kind_e kind);
    plan_row_t row;
    row.beat.command = cmd;
    row.beat.page    = PageW'(page);
    row.beat.frame   = FrameW'(frame);
    row.kind         = kind;
    return row;
  endfunction

  task automatic reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_config(bit mode, logic [7:0] id);
    reg_write(CfgPolicy, {{(CfgDataW-1){1'b0}}, mode});
    reg_write(CfgProcess, id);
    clock_m  = mode;
    owner_id = id;
    settings_used++;
  endtask

  // Lower valid and wait for every outstanding result
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_beat(in_beat_t b, exp_kind_e kind);
    int gap;
    out_beat_t r;
    gap = idle_draw(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    r = page_table_step(b);
    if (kind == ExpZero) begin
      r = '0;
    end else if (kind == ExpEmpty) begin
      r = '0;
      r.status = 1'b1;
    end
    pending_results.push_back(r);
    beats_sent++;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
  endtask

  task automatic check_field(string name, int expv, int got);
    if (expv != got) begin
      $error("%s: expected %0d, got %0d", name, expv, got);
      mismatches++;
    end
  endtask

  // Result side: random stall before each beat
  initial begin
    int hold;
    out_stall_i = 1'b0;
    recv_calm   = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = idle_draw(recv_calm);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending: %h", out_data_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("victim_page", want.victim_page, out_data_o.victim_page);
        check_field("victim_frame", want.victim_frame, out_data_o.victim_frame);
        check_field("needs_writeback", want.needs_writeback, out_data_o.needs_writeback);
        check_field("owner", want.owner, out_data_o.owner);
        check_field("status", want.status, out_data_o.status);
      end
    end
  end

  // Watchdog: cycles without any beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CfgPolicy;
    cfg_data_i  = '0;
    mismatches  = 0;
    beats_sent  = 0;
    settings_used = 0;
    replace_cnt = 0;
    writeback_cnt = 0;
    empty_cnt   = 0;
    send_calm   = 1'b0;
    hand_pos    = 0;
    clock_m     = 1'b0;
    owner_id    = '0;
    for (int p = 0; p < NPAGES; p++) begin
      pg_present[p] = 1'b0;
      pg_used[p]    = 1'b0;
      pg_dirty[p]   = 1'b0;
      pg_frame[p]   = '0;
    end

    // Directed: empty set, frame and page extremes, shared frames,
    // replace of a page already resident, reinstall clearing modified
    plan.push_back(mk_row(CmdReplace,  0,   0, ExpEmpty));
    plan.push_back(mk_row(CmdRead,     0,   0, ExpZero));
    plan.push_back(mk_row(CmdWrite,   63, 255, ExpZero));
    plan.push_back(mk_row(CmdInstall,  0,   0, ExpZero));
    plan.push_back(mk_row(CmdInstall, 63, 255, ExpZero));
    plan.push_back(mk_row(CmdInstall, 32, 170, ExpZero));
    plan.push_back(mk_row(CmdWrite,    0, 255, ExpZero));
    plan.push_back(mk_row(CmdRead,     0,   0, ExpZero));
    plan.push_back(mk_row(CmdReplace, 10,  85, ExpPredict));
    plan.push_back(mk_row(CmdReplace, 10,   0, ExpPredict));
    plan.push_back(mk_row(CmdInstall,  1,   0, ExpZero));
    plan.push_back(mk_row(CmdWrite,   63,   0, ExpZero));
    plan.push_back(mk_row(CmdRead,     0, 255, ExpZero));
    plan.push_back(mk_row(CmdReplace, 21, 255, ExpPredict));
    plan.push_back(mk_row(CmdReplace, 42,   1, ExpPredict));
    plan.push_back(mk_row(CmdInstall, 63,  85, ExpZero));
    plan.push_back(mk_row(CmdWrite,    0,  85, ExpZero));
    plan.push_back(mk_row(CmdReplace, 63, 255, ExpPredict));
    plan.push_back(mk_row(CmdReplace,  0,   0, ExpPredict));
    plan.push_back(mk_row(CmdInstall, 63, 255, ExpZero));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(1'b0, 8'd255);
    foreach (plan[i]) send_beat(plan[i].beat, plan[i].kind);

    // Random phases, register settings changed only while idle
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        settle_idle();
        case (ph)
          1: set_config(1'b1, 8'd0);
          2: set_config(1'b1, 8'd255);
          3: set_config(1'b0, 8'd0);
          default: set_config(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        endcase
      end
      for (int k = 0; k < PHASE_BEATS; k++) send_beat(random_beat(ph % 2 == 1), ExpPredict);
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d command beats under %0d register settings, %0d replace searches",
             beats_sent, settings_used, replace_cnt);
    $display("%0d victims needed write-back, %0d searches found the resident set empty",
             writeback_cnt, empty_cnt);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
